// ===== src/tcp_header_capture_parser_unit_macros.svh =====
// Assertion macros for the TCP header capture parser.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef TCP_HEADER_CAPTURE_PARSER_UNIT_MACROS_SVH
`define TCP_HEADER_CAPTURE_PARSER_UNIT_MACROS_SVH

// Check on every rising clock edge outside reset.
`define TCPHC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising clock edge, reset included.
`define TCPHC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/tcphc_pkg.sv =====
// Shared types and constants for the TCP header capture parser.
// Used by the controller, the datapath and the top level; no dependencies.
package tcphc_pkg;

    localparam logic [6:0] OFFSET_MAX     = 7'd127;
    localparam logic [6:0] OFF_ETYPE_HI   = 7'd12;
    localparam logic [6:0] OFF_ETYPE_LO   = 7'd13;
    localparam logic [6:0] ETH_HDR_BYTES  = 7'd14;
    localparam logic [6:0] OFF_IP_PROTO   = 7'd23;
    localparam logic [7:0] ETYPE_IPV4_HI  = 8'h08;
    localparam logic [7:0] ETYPE_IPV4_LO  = 8'h00;
    localparam logic [7:0] IP_PROTO_TCP   = 8'd6;
    localparam logic [3:0] MIN_IHL        = 4'd5;

    typedef struct packed {
        logic take;
        logic load;
    } tcphc_cmd_t;

    typedef struct packed {
        logic window_done;
        logic out_free;
        logic rd_final;
    } tcphc_status_t;

endpackage

// ===== src/tcphc_ctrl.sv =====
// Controller for the TCP header capture parser: capture and drain sequencing.
// Depends on tcphc_pkg for the command and status structs.
module tcphc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    frame_valid,
    output logic                    frame_stall,
    input  tcphc_pkg::tcphc_status_t sts,
    output tcphc_pkg::tcphc_cmd_t    cmd
);
    import tcphc_pkg::*;

    typedef enum logic [1:0] {
        S_CAPTURE = 2'b01,
        S_DRAIN   = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        frame_stall = 1'b1;
        cmd.take    = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            S_CAPTURE:
            begin
                frame_stall = 1'b0;
                cmd.take    = frame_valid;
                if (frame_valid && sts.window_done)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.load = sts.out_free;
                if (sts.out_free && sts.rd_final)
                begin
                    state_next = S_CAPTURE;
                end
            end
            default:
            begin
                state_next = S_CAPTURE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CAPTURE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/tcphc_datapath.sv =====
// Datapath for the TCP header capture parser: header checks, window memory, output register.
// Depends on tcphc_pkg and the assertion macros header.
module tcphc_datapath #(
    parameter int CAPTURE_BYTES = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               frame_byte,
    input  logic                     frame_end,
    output logic [7:0]               captured_byte,
    output logic                     capture_last,
    output logic                     capture_valid,
    input  logic                     capture_stall,
    input  tcphc_pkg::tcphc_cmd_t    cmd,
    output tcphc_pkg::tcphc_status_t sts
);
    import tcphc_pkg::*;
    `include "tcp_header_capture_parser_unit_macros.svh"

    localparam int AW = (CAPTURE_BYTES > 1) ? $clog2(CAPTURE_BYTES) : 1;
    localparam int CW = $clog2(CAPTURE_BYTES + 1);

    logic [6:0]    offset_reg;
    logic [6:0]    offset_next;
    logic [7:0]    etype_hi_reg;
    logic [7:0]    etype_hi_next;
    logic          rejected_reg;
    logic          rejected_next;
    logic [3:0]    ihl_reg;
    logic [3:0]    ihl_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_inc;
    logic [7:0]    start_off;
    logic          capture_en;
    logic          window_done;
    logic          wr_en;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    logic [7:0] window_mem [CAPTURE_BYTES];

    always_comb
    begin
        etype_hi_next = etype_hi_reg;
        rejected_next = rejected_reg;
        ihl_next      = ihl_reg;
        count_next    = count_reg;
        window_done   = 1'b0;
        if (!rejected_reg)
        begin
            if (offset_reg == OFF_ETYPE_HI)
            begin
                etype_hi_next = frame_byte;
            end
            else if (offset_reg == OFF_ETYPE_LO)
            begin
                if (etype_hi_reg != ETYPE_IPV4_HI || frame_byte != ETYPE_IPV4_LO)
                begin
                    rejected_next = 1'b1;
                end
            end
            else if (offset_reg == ETH_HDR_BYTES)
            begin
                ihl_next = frame_byte[3:0];
                if (frame_byte[3:0] < MIN_IHL)
                begin
                    rejected_next = 1'b1;
                end
            end
            else if (offset_reg == OFF_IP_PROTO)
            begin
                if (frame_byte != IP_PROTO_TCP)
                begin
                    rejected_next = 1'b1;
                end
            end
        end

        start_off  = {1'b0, ETH_HDR_BYTES} + {2'b00, ihl_next, 2'b00};
        capture_en = !rejected_next && (offset_reg > ETH_HDR_BYTES)
                     && ({1'b0, offset_reg} >= start_off);
        count_inc  = count_reg + CW'(1);
        if (capture_en)
        begin
            if (count_inc == CW'(CAPTURE_BYTES))
            begin
                window_done   = 1'b1;
                rejected_next = 1'b1;
                count_next    = '0;
            end
            else
            begin
                count_next = count_inc;
            end
        end

        offset_next = (offset_reg < OFFSET_MAX) ? offset_reg + 7'd1 : offset_reg;

        if (frame_end)
        begin
            offset_next   = '0;
            etype_hi_next = '0;
            rejected_next = 1'b0;
            ihl_next      = '0;
            count_next    = '0;
        end
    end

    assign wr_en = cmd.take && capture_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            etype_hi_reg <= '0;
            rejected_reg <= 1'b0;
            ihl_reg      <= '0;
            count_reg    <= '0;
        end
        else if (cmd.take)
        begin
            offset_reg   <= offset_next;
            etype_hi_reg <= etype_hi_next;
            rejected_reg <= rejected_next;
            ihl_reg      <= ihl_next;
            count_reg    <= count_next;
        end
    end

    assign sts.rd_final    = (rd_ptr_reg == AW'(CAPTURE_BYTES - 1));
    assign sts.out_free    = !out_valid_reg || !capture_stall;
    assign sts.window_done = window_done;
    assign rd_ptr_next     = sts.rd_final ? '0 : rd_ptr_reg + AW'(1);

    // Window memory: written during capture, read into the output register during drain.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            window_mem[count_reg[AW-1:0]] <= frame_byte;
        end
        if (cmd.load)
        begin
            out_byte_reg <= window_mem[rd_ptr_reg];
            out_last_reg <= sts.rd_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_ptr_reg    <= rd_ptr_next;
                out_valid_reg <= 1'b1;
            end
            else if (!capture_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign captured_byte = out_byte_reg;
    assign capture_last  = out_last_reg;
    assign capture_valid = out_valid_reg;

    `TCPHC_ASSERT(a_count_in_range, clk, rst_n, count_reg < CW'(CAPTURE_BYTES), "window count out of range")
    `TCPHC_ASSERT(a_no_take_in_drain, clk, rst_n, !(cmd.take && cmd.load), "transfer taken while draining")
    `TCPHC_ASSERT(a_burst_from_zero, clk, rst_n, (cmd.take && window_done) |=> (rd_ptr_reg == '0), "burst does not start at entry zero")
    `TCPHC_ASSERT_ALWAYS(a_reset_clear, clk, (!rst_n) |=> (count_reg == '0 && !out_valid_reg), "state not cleared in reset")

endmodule

// ===== src/tcp_header_capture_parser_unit.sv =====
// The parser accepts one Ethernet frame byte per cycle while capturing. Frames must carry
// EtherType 0x0800, an IPv4 header length of at least 5 and protocol 6; from offset
// 14 + 4 * header length the next CAPTURE_BYTES bytes are stored in a window memory. The
// byte that completes the window is followed by a drain of CAPTURE_BYTES bytes, one byte
// per cycle unless capture_stall is held, through the memory's single read port, during
// which frame_stall is high. Short or failing frames produce nothing.
// Top level: instantiates tcphc_ctrl and tcphc_datapath; depends on tcphc_pkg.
module tcp_header_capture_parser_unit #(
    parameter int CAPTURE_BYTES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       frame_valid,
    output logic       frame_stall,
    input  logic [7:0] frame_byte,
    input  logic       frame_end,
    output logic       capture_valid,
    input  logic       capture_stall,
    output logic [7:0] captured_byte,
    output logic       capture_last
);
    import tcphc_pkg::*;

    tcphc_cmd_t    cmd;
    tcphc_status_t sts;

    tcphc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    tcphc_datapath #(
        .CAPTURE_BYTES (CAPTURE_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_byte    (frame_byte),
        .frame_end     (frame_end),
        .captured_byte (captured_byte),
        .capture_last  (capture_last),
        .capture_valid (capture_valid),
        .capture_stall (capture_stall),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// ===== test/tcp_header_capture_parser_unit_checker.sv =====
`timescale 1ns / 100ps
// Checker for tcp_header_capture_parser_unit: watches both channels, predicts each capture burst.
// Depends on tcphc_pkg for frame offsets and match values.
module tcp_header_capture_parser_unit_checker #(
    parameter int CAPTURE_BYTES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       frame_valid,
    input  logic       frame_stall,
    input  logic [7:0] frame_byte,
    input  logic       frame_end,
    input  logic       capture_valid,
    input  logic       capture_stall,
    input  logic [7:0] captured_byte,
    input  logic       capture_last,
    output int         failures,
    output int         pending
);
    import tcphc_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } capture_beat_t;

    capture_beat_t burst_q[$];

    logic [6:0] offset;
    logic [7:0] etype_hi;
    logic       dropped;
    logic [3:0] ihl;
    logic [7:0] window [CAPTURE_BYTES];
    logic [5:0] fill_count;

    task automatic clear_frame();
        offset = '0;
        etype_hi = '0;
        dropped = 1'b0;
        ihl = '0;
        fill_count = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fin);
        logic [6:0] pos;
        int start;
        int idx;
        capture_beat_t beat;
        pos = offset;
        if (!dropped) begin
            if (pos == OFF_ETYPE_HI) begin
                etype_hi = b;
            end
            else if (pos == OFF_ETYPE_LO) begin
                if (etype_hi != ETYPE_IPV4_HI || b != ETYPE_IPV4_LO)
                    dropped = 1'b1;
            end
            else if (pos == ETH_HDR_BYTES) begin
                ihl = b[3:0];
                if (b[3:0] < MIN_IHL)
                    dropped = 1'b1;
            end
            else if (pos == OFF_IP_PROTO) begin
                if (b != IP_PROTO_TCP)
                    dropped = 1'b1;
            end
        end
        start = int'(ETH_HDR_BYTES) + 4 * int'(ihl);
        if (!dropped && pos > ETH_HDR_BYTES && int'(pos) >= start) begin
            idx = int'(fill_count);
            if (idx < CAPTURE_BYTES) begin
                window[idx] = b;
                idx++;
            end
            if (idx >= CAPTURE_BYTES) begin
                for (int k = 0; k < CAPTURE_BYTES; k++) begin
                    beat.data = window[k];
                    beat.last = (k == CAPTURE_BYTES - 1);
                    burst_q.push_back(beat);
                end
                dropped = 1'b1;
                fill_count = '0;
            end
            else begin
                fill_count = 6'(idx);
            end
        end
        if (offset < OFFSET_MAX)
            offset++;
        if (fin)
            clear_frame();
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        capture_beat_t beat;
        if (!rst_n) begin
            clear_frame();
            burst_q.delete();
            failures = 0;
            pending <= 0;
        end
        else begin
            if (frame_valid && !frame_stall)
                parse_byte(frame_byte, frame_end);
            if (capture_valid && !capture_stall) begin
                if (burst_q.size() == 0) begin
                    $error("unexpected capture transfer: captured_byte %02h, capture_last %0b",
                           captured_byte, capture_last);
                    failures++;
                end
                else begin
                    beat = burst_q.pop_front();
                    if (captured_byte !== beat.data) begin
                        $error("captured_byte: expected %02h, actual %02h",
                               beat.data, captured_byte);
                        failures++;
                    end
                    if (capture_last !== beat.last) begin
                        $error("capture_last: expected %0b, actual %0b",
                               beat.last, capture_last);
                        failures++;
                    end
                end
            end
            pending <= burst_q.size();
        end
    end

endmodule

// ===== test/tcp_header_capture_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the tcp_header_capture_parser_unit testbench: clock, reset, frame stimulus and verdict.
// Depends on tcphc_pkg, the block and tcp_header_capture_parser_unit_checker.
module tcp_header_capture_parser_unit_tb;
    import tcphc_pkg::*;

    localparam int CAPTURE_BYTES = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_FILL = -1;
    localparam logic [7:0] ETYPE_IPV6_HI = 8'h86;
    localparam logic [7:0] ETYPE_IPV6_LO = 8'hDD;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       frame_valid = 1'b0;
    logic       frame_stall;
    logic [7:0] frame_byte = 8'h00;
    logic       frame_end = 1'b0;
    logic       capture_valid;
    logic       capture_stall = 1'b0;
    logic [7:0] captured_byte;
    logic       capture_last;
    logic       steady = 1'b0;
    int         failures;
    int         pending;
    int         cycles = 0;

    tcp_header_capture_parser_unit #(
        .CAPTURE_BYTES(CAPTURE_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .frame_valid(frame_valid),
        .frame_stall(frame_stall),
        .frame_byte(frame_byte),
        .frame_end(frame_end),
        .capture_valid(capture_valid),
        .capture_stall(capture_stall),
        .captured_byte(captured_byte),
        .capture_last(capture_last)
    );

    tcp_header_capture_parser_unit_checker #(
        .CAPTURE_BYTES(CAPTURE_BYTES)
    ) capture_checker (
        .clk(clk),
        .rst_n(rst_n),
        .frame_valid(frame_valid),
        .frame_stall(frame_stall),
        .frame_byte(frame_byte),
        .frame_end(frame_end),
        .capture_valid(capture_valid),
        .capture_stall(capture_stall),
        .captured_byte(captured_byte),
        .capture_last(capture_last),
        .failures(failures),
        .pending(pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        capture_stall <= !steady && ($urandom_range(99) < 26);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL tcp_header_capture_parser_unit");
            $finish;
        end
    end

    function automatic int full_length(input int ihl);
        return int'(ETH_HDR_BYTES) + 4 * ihl + CAPTURE_BYTES;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!steady && $urandom_range(99) < 26) begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_byte <= b;
        frame_end <= fin;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
    endtask

    task automatic send_frame(input int length, input logic [7:0] hi, input logic [7:0] lo,
                              input logic [3:0] ihl, input logic [7:0] proto, input int fill);
        logic [7:0] data;
        for (int i = 0; i < length; i++) begin
            data = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (i == int'(OFF_ETYPE_HI))
                data = hi;
            else if (i == int'(OFF_ETYPE_LO))
                data = lo;
            else if (i == int'(ETH_HDR_BYTES))
                data = {data[7:4], ihl};
            else if (i == int'(OFF_IP_PROTO))
                data = proto;
            send_byte(data, i == length - 1);
        end
    endtask

    task automatic send_tcp_frame(input int length, input int ihl, input int fill);
        send_frame(length, ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'(ihl), IP_PROTO_TCP, fill);
    endtask

    task automatic wait_drained();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        steady = 1'b1;
        send_frame(int'(ETH_HDR_BYTES), ETYPE_IPV6_HI, ETYPE_IPV6_LO, 4'd5, IP_PROTO_TCP,
                   RANDOM_FILL);
        send_tcp_frame(int'(OFF_IP_PROTO) + 1, 5, RANDOM_FILL);
        steady = 1'b0;

        send_tcp_frame(full_length(5) + 2, 5, RANDOM_FILL);
        wait_drained();

        send_tcp_frame(1, 5, RANDOM_FILL);
        wait_drained();
        repeat (4 * CAPTURE_BYTES) @(posedge clk);

        if (failures == 0)
            $display("PASS tcp_header_capture_parser_unit");
        else
            $display("FAIL tcp_header_capture_parser_unit");
        $finish;
    end

endmodule
